// ===== rtl/tbk_pkg.sv =====
// Shared types and constants of the timer and clock bank.
// No dependencies; the timer cell, the clock cell and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package tbk_pkg;

    // Fixed field widths
    localparam int WORD_W   = 16;
    localparam int IDX_W    = 6;
    localparam int MODE_W   = 3;
    localparam int CFG_W    = 2;
    localparam int SLOT_MAX = 64;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0]  t_idx;

    // Command codes
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK        = 3'd0,
        MODE_CLEAR_ACCUM = 3'd1,
        MODE_APPLY       = 3'd2,
        MODE_WRITE_TIMER = 3'd3,
        MODE_READ_TIMER  = 3'd4,
        MODE_READ_CLOCK  = 3'd5,
        MODE_RDCLR_CLOCK = 3'd6,
        MODE_CLEAR_ALL   = 3'd7
    } t_mode;

    // Configuration register indexes
    localparam logic [CFG_W-1:0] CFG_TICK_STEP   = 2'd0;
    localparam logic [CFG_W-1:0] CFG_PRESCALE_ON = 2'd1;
    localparam logic [CFG_W-1:0] CFG_PRESCALE_F  = 2'd2;

    // Command packet passed from cell to cell
    typedef struct packed {
        logic  valid;
        t_mode mode;
        t_idx  index;
        t_word value;
        t_word amt;       // elapsed amount, scaled if prescale is on; zero unless apply
        t_word rd;        // read data gathered on the way
        logic  all_zero;  // every timer seen so far is zero
    } t_pkt;

endpackage

`default_nettype wire

// ===== rtl/tbk_in_if.sv =====
// Command channel of the timer and clock bank: valid/ready plus one command.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface tbk_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [5:0]  index;
    logic [15:0] value;

    modport source (output valid, mode, index, value, input ready);
    modport sink   (input valid, mode, index, value, output ready);
endinterface

`default_nettype wire

// ===== rtl/tbk_out_if.sv =====
// Result channel of the timer and clock bank: valid/ready plus one result.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface tbk_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_value;
    logic [15:0] elapsed_applied;
    logic        may_sleep;

    modport source (output valid, read_value, elapsed_applied, may_sleep, input ready);
    modport sink   (input valid, read_value, elapsed_applied, may_sleep, output ready);
endinterface

`default_nettype wire

// ===== rtl/tbk_timer_cell.sv =====
// One countdown timer cell: holds a timer and acts on the passing command.
// Depends on tbk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbk_timer_cell #(
    parameter int IDX = 0
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  tbk_pkg::t_pkt i_pkt,
    output tbk_pkg::t_pkt o_pkt
);
    import tbk_pkg::*;

    t_word r_val, n_val;
    t_pkt  r_pkt, n_pkt;
    logic  hit;

    assign hit = (i_pkt.index == IDX_W'(IDX));

    // Apply the command to this timer and forward it
    always_comb begin
        n_val = r_val;
        n_pkt = i_pkt;
        if (i_pkt.valid) begin
            unique case (i_pkt.mode)
                MODE_WRITE_TIMER: begin
                    if (hit) n_val = i_pkt.value;
                end
                MODE_READ_TIMER: begin
                    if (hit) n_pkt.rd = r_val;
                end
                MODE_APPLY: begin
                    n_val = (r_val > i_pkt.amt) ? t_word'(r_val - i_pkt.amt) : '0;
                end
                MODE_CLEAR_ALL: begin
                    n_val = '0;
                end
                default: begin
                end
            endcase
        end
        n_pkt.all_zero = i_pkt.all_zero & (n_val == '0);
    end

    // Hold timer value and the outgoing packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
            r_pkt <= '0;
        end else begin
            r_val <= n_val;
            r_pkt <= n_pkt;
        end
    end

    assign o_pkt = r_pkt;

endmodule

`default_nettype wire

// ===== rtl/tbk_clock_cell.sv =====
// One up-counting clock cell: holds a clock and acts on the passing command.
// Depends on tbk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbk_clock_cell #(
    parameter int IDX = 0
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  tbk_pkg::t_pkt i_pkt,
    output tbk_pkg::t_pkt o_pkt
);
    import tbk_pkg::*;

    t_word r_val, n_val;
    t_pkt  r_pkt, n_pkt;
    logic  hit;

    assign hit = (i_pkt.index == IDX_W'(IDX));

    // Apply the command to this clock and forward it
    always_comb begin
        n_val = r_val;
        n_pkt = i_pkt;
        if (i_pkt.valid) begin
            unique case (i_pkt.mode)
                MODE_READ_CLOCK: begin
                    if (hit) n_pkt.rd = r_val;
                end
                MODE_RDCLR_CLOCK: begin
                    if (hit) begin
                        n_pkt.rd = r_val;
                        n_val    = '0;
                    end
                end
                MODE_APPLY: begin
                    n_val = t_word'(r_val + i_pkt.amt);
                end
                MODE_CLEAR_ALL: begin
                    n_val = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Hold clock value and the outgoing packet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
            r_pkt <= '0;
        end else begin
            r_val <= n_val;
            r_pkt <= n_pkt;
        end
    end

    assign o_pkt = r_pkt;

endmodule

`default_nettype wire

// ===== rtl/countdown_timer_and_clock_bank.sv =====
// Bank of countdown timers and up-counting clocks with an elapsed-time accumulator.
// Top level; depends on tbk_pkg, tbk_in_if, tbk_out_if, tbk_timer_cell, tbk_clock_cell.
// One command is handled at a time. An accepted command is registered at the head,
// where the accumulator is updated and the elapsed amount taken, scaled if prescale
// is on, then walks a row of cells, one register per timer or clock, and lands in
// the output register. The next command is taken only after the result beat has
// been accepted. Configuration writes take effect at once and are to be made only
// while no command is in flight.
`timescale 1ns / 1ps
`default_nettype none

module countdown_timer_and_clock_bank #(
    parameter int TIMER_COUNT = 8,
    parameter int CLOCK_COUNT = 4
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    tbk_in_if.sink                    i_cmd,
    tbk_out_if.source                 o_res,
    input  wire                       i_cfg_we,
    input  wire [tbk_pkg::CFG_W-1:0]  i_cfg_idx,
    input  wire [tbk_pkg::WORD_W-1:0] i_cfg_data
);
    import tbk_pkg::*;

    localparam int   TU        = (TIMER_COUNT > SLOT_MAX) ? SLOT_MAX : TIMER_COUNT;
    localparam int   CU        = (CLOCK_COUNT > SLOT_MAX) ? SLOT_MAX : CLOCK_COUNT;
    localparam int   NCELL     = TU + CU;
    localparam logic NO_CLOCKS = (CU == 0);

    // Configuration registers
    t_word r_tick_step;
    logic  r_prescale_on;
    t_word r_prescale_f;

    // Head stage
    t_word r_accum, n_accum;
    t_pkt  r_head, n_head;
    logic  r_busy;
    logic  cmd_acc, res_acc;
    t_mode cmd_mode;
    t_word prod;

    // Output register
    logic  r_ovalid;
    t_word r_rd;
    t_word r_applied;
    logic  r_sleep;

    t_pkt  chain [NCELL+1];

    assign cmd_mode = t_mode'(i_cmd.mode);
    assign cmd_acc  = i_cmd.valid & i_cmd.ready;
    assign res_acc  = o_res.valid & o_res.ready;
    assign i_cmd.ready = !r_busy;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_step   <= WORD_W'(1);
            r_prescale_on <= 1'b0;
            r_prescale_f  <= WORD_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TICK_STEP: begin
                    r_tick_step <= i_cfg_data;
                end
                CFG_PRESCALE_ON: begin
                    r_prescale_on <= i_cfg_data[0];
                end
                CFG_PRESCALE_F: begin
                    r_prescale_f <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Scale the accumulator and update it for the incoming command
    assign prod = t_word'(r_accum * r_prescale_f);

    always_comb begin
        n_accum        = r_accum;
        n_head         = '0;
        n_head.valid   = cmd_acc;
        n_head.mode    = cmd_mode;
        n_head.index   = i_cmd.index;
        n_head.value   = i_cmd.value;
        n_head.all_zero = 1'b1;
        if (cmd_acc) begin
            unique case (cmd_mode)
                MODE_TICK: begin
                    n_accum = t_word'(r_accum + r_tick_step);
                end
                MODE_CLEAR_ACCUM: begin
                    n_accum = '0;
                end
                MODE_APPLY: begin
                    n_accum    = '0;
                    n_head.amt = r_prescale_on ? prod : r_accum;
                end
                default: begin
                end
            endcase
        end
    end

    // Hold accumulator, head packet and the busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
            r_head  <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_accum <= n_accum;
            r_head  <= n_head;
            if (cmd_acc) begin
                r_busy <= 1'b1;
            end else if (res_acc) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign chain[0] = r_head;

    // Row of timer cells, then row of clock cells
    genvar g;
    generate
        for (g = 0; g < TU; g++) begin : g_timer
            tbk_timer_cell #(.IDX(g)) u_timer (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_pkt   (chain[g]),
                .o_pkt   (chain[g+1])
            );
        end
        for (g = 0; g < CU; g++) begin : g_clock
            tbk_clock_cell #(.IDX(g)) u_clock (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_pkt   (chain[TU+g]),
                .o_pkt   (chain[TU+g+1])
            );
        end
    endgenerate

    // Capture the finished command into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (chain[NCELL].valid) begin
            r_ovalid <= 1'b1;
        end else if (res_acc) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (chain[NCELL].valid) begin
            r_rd      <= chain[NCELL].rd;
            r_applied <= chain[NCELL].amt;
            r_sleep   <= NO_CLOCKS & chain[NCELL].all_zero;
        end
    end

    assign o_res.valid           = r_ovalid;
    assign o_res.read_value      = r_rd;
    assign o_res.elapsed_applied = r_applied;
    assign o_res.may_sleep       = r_sleep;

endmodule

`default_nettype wire

// ===== rtl/tbk_checker.sv =====
// Port-level checks of the timer and clock bank and their bind to the top level.
// Depends on countdown_timer_and_clock_bank.
`timescale 1ns / 1ps
`default_nettype none

module tbk_checker #(
    parameter int CLOCK_COUNT = 4
) (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [15:0] i_read_value,
    input wire [15:0] i_elapsed_applied,
    input wire        i_may_sleep
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_read_value)
            && $stable(i_elapsed_applied) && $stable(i_may_sleep))
        else $error("result beat changed while stalled");

    // Drop ready once a command is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command taken while another is in flight");

    // Hold off commands while a result waits
    a_no_take_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("ready while result pending");

    // Clocks forbid sleep
    a_sleep_clocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (CLOCK_COUNT != 0) |-> !i_may_sleep)
        else $error("may_sleep raised with clocks present");

endmodule

bind countdown_timer_and_clock_bank tbk_checker #(.CLOCK_COUNT(CLOCK_COUNT)) u_tbk_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_cmd.valid),
    .i_in_ready        (i_cmd.ready),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_read_value      (o_res.read_value),
    .i_elapsed_applied (o_res.elapsed_applied),
    .i_may_sleep       (o_res.may_sleep)
);

`default_nettype wire
